// ----- hw/rtl/mtu_pkg.sv -----
// mtu_pkg: shared types and constants for the midi to usb event packer
// no dependencies; imported by the packer, the output register, the top level and the checker
package mtu_pkg;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_ONE     = 2'd1,
        KIND_TWO     = 2'd2,
        KIND_SYSEX   = 2'd3
    } kind_t;

    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] SYSEX_END      = 8'hF7;
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END  = 4'h5;

    localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
    localparam logic [3:0] HI_NOTE_ON     = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS  = 4'hA;
    localparam logic [3:0] HI_CONTROL     = 4'hB;
    localparam logic [3:0] HI_PROGRAM     = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND  = 4'hE;
    localparam logic [3:0] HI_SYSTEM      = 4'hF;

    typedef struct packed {
        logic [3:0] code_index;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } packet_t;

    // data byte position: (p + 1) mod 3
    function automatic logic [1:0] phase_advance(input logic [1:0] p);
        phase_advance = (p >= 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

endpackage

// ----- hw/rtl/midi_to_usb_event_packer.sv -----
// midi_to_usb_event_packer: top level, input register, packer and result register
// depends on mtu_pkg, mtu_packer, mtu_out_reg
//
// Takes serial MIDI bytes one per transaction and turns them into 4-byte USB-MIDI event
// packets for cable 0. Status bytes set the message kind, running status is honored, SysEx
// goes out in groups of three with code 4 and F7 closes it with code 5, 6 or 7; bytes that
// complete no packet produce no result transaction. The block takes one byte every cycle:
// each byte waits in the input register, is folded into the packet state by the packer
// while it waits there and, if a packet completes, is loaded into the result register at
// the edge that moves it on, so a result reaches the m_ port through those two registers.
// Only back-pressure on the result port slows intake, since the input register then
// holds until the result register frees up.
module midi_to_usb_event_packer
    import mtu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // byte input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_midi_byte,
    // packet output
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_code_index,
    output logic [7:0] m_first_byte,
    output logic [7:0] m_second_byte,
    output logic [7:0] m_third_byte
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;

    logic       can_load;
    logic       advance;
    logic       emit;
    packet_t    packet;
    packet_t    m_packet;

    // the held byte moves on once the result register can take whatever it makes
    assign advance = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            if (s_valid) begin
                in_byte_next = s_midi_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    // per-byte state update
    mtu_packer u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .midi_byte (in_byte_reg),
        .emit      (emit),
        .packet    (packet)
    );

    // result register
    mtu_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .packet   (packet),
        .m_ready  (m_ready),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_packet (m_packet)
    );

    assign m_code_index  = m_packet.code_index;
    assign m_first_byte  = m_packet.first_byte;
    assign m_second_byte = m_packet.second_byte;
    assign m_third_byte  = m_packet.third_byte;

endmodule

// ----- hw/rtl/mtu_packer.sv -----
// mtu_packer: message kind, byte phase and packet assembly for one midi byte per step
// depends on mtu_pkg
module mtu_packer
    import mtu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] midi_byte,
    output logic       emit,
    output packet_t    packet
);

    kind_t      kind_reg, kind_next;
    logic [1:0] phase_reg, phase_next;
    packet_t    pkt_reg, pkt_next;

    logic [3:0] hi;
    logic [1:0] slot;
    logic [1:0] data_count;

    assign hi = midi_byte[7:4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_UNKNOWN;
            phase_reg <= 2'd0;
            pkt_reg   <= '0;
        end else begin
            kind_reg  <= kind_next;
            phase_reg <= phase_next;
            pkt_reg   <= pkt_next;
        end
    end

    always_comb begin
        kind_next  = kind_reg;
        phase_next = phase_reg;
        pkt_next   = pkt_reg;
        emit       = 1'b0;
        slot       = phase_advance(phase_reg);
        data_count = {1'b0, phase_reg[0]} + 2'd1;
        if (step) begin
            if (midi_byte[7]) begin
                if (midi_byte == SYSEX_END) begin
                    // end of exclusive always closes a group, whatever the kind
                    phase_next = slot;
                    case (slot)
                        2'd0:    pkt_next.first_byte  = midi_byte;
                        2'd1:    pkt_next.second_byte = midi_byte;
                        default: pkt_next.third_byte  = midi_byte;
                    endcase
                    pkt_next.code_index = CIN_SYSEX_END + {2'b00, slot};
                    kind_next = KIND_UNKNOWN;
                    emit      = 1'b1;
                end else begin
                    case (hi)
                        HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CONTROL,
                        HI_PITCH_BEND:              kind_next = KIND_TWO;
                        HI_PROGRAM, HI_CHAN_PRESS:  kind_next = KIND_ONE;
                        HI_SYSTEM: begin
                            kind_next = (midi_byte == SYSEX_START) ? KIND_SYSEX
                                                                   : KIND_UNKNOWN;
                        end
                        default:                    kind_next = KIND_UNKNOWN;
                    endcase
                    pkt_next.code_index  = hi;
                    pkt_next.first_byte  = midi_byte;
                    pkt_next.second_byte = 8'h00;
                    pkt_next.third_byte  = 8'h00;
                    phase_next           = 2'd0;
                end
            end else begin
                case (kind_reg)
                    KIND_ONE, KIND_TWO: begin
                        if (phase_reg[0]) begin
                            pkt_next.third_byte = midi_byte;
                        end else begin
                            pkt_next.second_byte = midi_byte;
                        end
                        if (data_count == kind_reg) begin
                            phase_next = 2'd0;
                            emit       = 1'b1;
                        end else begin
                            phase_next = data_count;
                        end
                    end
                    KIND_SYSEX: begin
                        phase_next = slot;
                        case (slot)
                            2'd0: begin
                                pkt_next.first_byte  = midi_byte;
                                pkt_next.second_byte = 8'h00;
                                pkt_next.third_byte  = 8'h00;
                            end
                            2'd1:    pkt_next.second_byte = midi_byte;
                            default: begin
                                pkt_next.third_byte = midi_byte;
                                pkt_next.code_index = CIN_SYSEX_CONT;
                                emit                = 1'b1;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end

    // packet goes out with the bytes as they stand after this update
    assign packet = pkt_next;

endmodule

// ----- hw/rtl/mtu_out_reg.sv -----
// mtu_out_reg: result register that holds one finished packet until the sink takes it
// depends on mtu_pkg
module mtu_out_reg
    import mtu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  packet_t packet,
    input  logic    m_ready,
    output logic    can_load,
    output logic    m_valid,
    output packet_t m_packet
);

    logic    valid_reg, valid_next;
    packet_t data_reg, data_next;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (can_load) begin
            valid_next = load;
            if (load) begin
                data_next = packet;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid  = valid_reg;
    assign m_packet = data_reg;

endmodule

// ----- hw/rtl/mtu_checker.sv -----
// mtu_checker: port-level assertions for the midi to usb event packer, bound to the top level
// depends on mtu_pkg and midi_to_usb_event_packer
module mtu_checker
    import mtu_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_code_index,
    input logic [7:0] m_first_byte,
    input logic [7:0] m_second_byte,
    input logic [7:0] m_third_byte
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_index) && $stable(m_first_byte)
            && $stable(m_second_byte) && $stable(m_third_byte))
        else $error("stalled result changed");

    // no codes 0..3 and no system code ever leave the block
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_code_index >= CIN_SYSEX_CONT) && (m_code_index != HI_SYSTEM))
        else $error("impossible code index");

    // sysex end packet carries F7 at the slot its code names
    a_eox: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_code_index == CIN_SYSEX_END) ? (m_first_byte == SYSEX_END) : 1'b1)
            && ((m_code_index == CIN_SYSEX_END + 4'd1) ? (m_second_byte == SYSEX_END) : 1'b1)
            && ((m_code_index == CIN_SYSEX_END + 4'd2) ? (m_third_byte == SYSEX_END) : 1'b1))
        else $error("sysex end byte misplaced");

    // channel messages carry their own status nibble as code
    a_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_code_index[3] |-> m_first_byte[7:4] == m_code_index)
        else $error("channel packet status mismatch");

    // nothing is offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind midi_to_usb_event_packer mtu_checker u_mtu_checker (.*);

// ----- sim/tb_midi_to_usb_event_packer.sv -----
// tb_midi_to_usb_event_packer: self-checking testbench for the midi to usb event packer
// drives serial MIDI bytes, predicts each USB-MIDI packet and checks the m_ channel
// depends on mtu_pkg and midi_to_usb_event_packer from hw/rtl
module tb_midi_to_usb_event_packer;
    import mtu_pkg::*;

    // cycles with no transaction on either channel before the run is declared hung
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 500;

    typedef struct {
        logic [7:0] value;
        bit         drain_first; // hold this byte until every expected packet has come
    } midi_item_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_BURSTY
    } ready_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_midi_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_code_index;
    logic [7:0] m_first_byte;
    logic [7:0] m_second_byte;
    logic [7:0] m_third_byte;

    midi_item_t pending_bytes[$];
    packet_t    expected_packets[$];

    // predicted packer state
    kind_t      pk_kind = KIND_UNKNOWN;
    logic [1:0] pk_phase = 2'd0;
    logic [3:0] pk_cin = 4'h0;
    logic [7:0] pk_bytes[1:3] = '{8'h00, 8'h00, 8'h00};

    int error_count = 0;
    int bytes_accepted = 0;
    int packets_predicted = 0;
    int packets_seen = 0;
    int sysex_cont_seen = 0;
    int sysex_end_seen = 0;

    midi_to_usb_event_packer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_midi_byte   (s_midi_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_index  (m_code_index),
        .m_first_byte  (m_first_byte),
        .m_second_byte (m_second_byte),
        .m_third_byte  (m_third_byte)
    );

    always #5 aclk = ~aclk;

    // sysex slot position: (p + 1) mod 3
    function automatic logic [1:0] next_slot(input logic [1:0] p);
        return (p == 2'd2 || p == 2'd3) ? 2'd0 : p + 2'd1;
    endfunction

    // fold one accepted byte into the predicted state, queue a packet if one completes
    task automatic fold_midi_byte(input logic [7:0] b);
        logic [3:0] hi;
        logic [1:0] slot;
        bit         emit;
        packet_t    pkt;
        hi = b[7:4];
        emit = 1'b0;
        if (b[7]) begin
            if (b == SYSEX_END) begin
                // F7 lands at the next slot whatever the kind, and always closes a packet
                slot = next_slot(pk_phase);
                pk_phase = slot;
                pk_bytes[1 + slot] = b;
                pk_cin = CIN_SYSEX_END + {2'b00, slot};
                pk_kind = KIND_UNKNOWN;
                emit = 1'b1;
            end else begin
                case (hi)
                    HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CONTROL, HI_PITCH_BEND: begin
                        pk_kind = KIND_TWO;
                    end
                    HI_PROGRAM, HI_CHAN_PRESS: begin
                        pk_kind = KIND_ONE;
                    end
                    default: begin
                        pk_kind = (b == SYSEX_START) ? KIND_SYSEX : KIND_UNKNOWN;
                    end
                endcase
                pk_cin = hi;
                pk_bytes[1] = b;
                pk_bytes[2] = 8'h00;
                pk_bytes[3] = 8'h00;
                pk_phase = 2'd0;
            end
        end else if (pk_kind == KIND_ONE || pk_kind == KIND_TWO) begin
            // running status: status stays, data bytes refill slots 2 and 3
            pk_bytes[2 + pk_phase[0]] = b;
            pk_phase = {1'b0, pk_phase[0]} + 2'd1;
            if (pk_phase == pk_kind) begin
                pk_phase = 2'd0;
                emit = 1'b1;
            end
        end else if (pk_kind == KIND_SYSEX) begin
            slot = next_slot(pk_phase);
            pk_phase = slot;
            pk_bytes[1 + slot] = b;
            if (slot == 2'd0) begin
                pk_bytes[2] = 8'h00;
                pk_bytes[3] = 8'h00;
            end
            if (slot == 2'd2) begin
                pk_cin = CIN_SYSEX_CONT;
                emit = 1'b1;
            end
        end
        // data bytes with no known kind fall through untouched
        if (emit) begin
            pkt.code_index = pk_cin;
            pkt.first_byte = pk_bytes[1];
            pkt.second_byte = pk_bytes[2];
            pkt.third_byte = pk_bytes[3];
            expected_packets.push_back(pkt);
            packets_predicted++;
        end
    endtask

    // driver: bursts of transactions with random gaps, fed from pending_bytes
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin : drive_bytes
        logic next_valid;
        next_valid = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                fold_midi_byte(pending_bytes[0].value);
                void'(pending_bytes.pop_front());
                bytes_accepted++;
            end
            // valid stays up with the same byte until the transaction happens
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bytes.size() == 0) begin
                    next_valid = 1'b0;
                end else if (pending_bytes[0].drain_first &&
                             packets_predicted != packets_seen) begin
                    next_valid = 1'b0;
                end else begin
                    next_valid = 1'b1;
                    s_midi_byte <= pending_bytes[0].value;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // mostly short bursts, sometimes a long stretch with no gaps
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left = $urandom_range(60, 150);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 30);
                            gap_left = $urandom_range(0, 12);
                        end
                    end
                end
                s_valid <= next_valid;
            end
        end
    end

    // receiver back-pressure, switching between a few patterns
    ready_mode_t ready_mode = RDY_ALWAYS;
    int mode_left = 0;
    int stall_left = 0;
    int ready_tick = 0;

    always @(posedge aclk) begin : drive_ready
        logic rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                RDY_ALWAYS: rdy = 1'b1;
                RDY_RANDOM: rdy = ($urandom_range(0, 9) < 7);
                RDY_PERIODIC: rdy = ((ready_tick % 8) >= 5);
                RDY_BURSTY: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy = 1'b0;
                    end else begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(5, 20);
                        end
                    end
                end
            endcase
            ready_tick++;
            m_ready <= rdy;
        end
    end

    // monitor: each packet transaction against the oldest expected packet
    always @(posedge aclk) begin : check_packets
        packet_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_packets.size() == 0) begin
                $error("unexpected packet: code_index %h bytes %h %h %h",
                       m_code_index, m_first_byte, m_second_byte, m_third_byte);
                error_count++;
            end else begin
                want = expected_packets.pop_front();
                if (m_code_index !== want.code_index) begin
                    $error("code_index: expected %h, actual %h", want.code_index, m_code_index);
                    error_count++;
                end
                if (m_first_byte !== want.first_byte) begin
                    $error("first_byte: expected %h, actual %h", want.first_byte, m_first_byte);
                    error_count++;
                end
                if (m_second_byte !== want.second_byte) begin
                    $error("second_byte: expected %h, actual %h",
                           want.second_byte, m_second_byte);
                    error_count++;
                end
                if (m_third_byte !== want.third_byte) begin
                    $error("third_byte: expected %h, actual %h", want.third_byte, m_third_byte);
                    error_count++;
                end
                if (want.code_index == CIN_SYSEX_CONT) begin
                    sysex_cont_seen++;
                end else if (want.code_index >= CIN_SYSEX_END && want.code_index <= 4'h7 &&
                             (want.first_byte == SYSEX_END || want.second_byte == SYSEX_END ||
                              want.third_byte == SYSEX_END)) begin
                    sysex_end_seen++;
                end
            end
            packets_seen <= packets_seen + 1;
        end
    end

    // watchdog: too long with no transaction means the block is stuck
    int idle_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d cycles with no transaction", IDLE_LIMIT);
                $display("tb_midi_to_usb_event_packer: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input bit drain);
        midi_item_t it;
        it.value = b;
        it.drain_first = drain;
        pending_bytes.push_back(it);
    endtask

    initial begin : stimulus
        logic [7:0] directed_bytes[26];
        int         random_items;
        int         next_drain;
        int         n_data;
        int         n_repeat;
        int         pick;
        bit         drain;
        logic [7:0] status;

        // directed: ignored data, note on with running status, program change,
        // sysex closing at each slot (one with stale bytes), stray F7,
        // system bytes breaking a pitch bend
        directed_bytes = '{
            8'h00,
            8'h90, 8'h00, 8'h7F, 8'h40,
            8'hC5, 8'h7F,
            8'hF0, 8'h01, 8'hF7,
            8'hF0, 8'h11, 8'h22, 8'hF7,
            8'hF0, 8'h01, 8'h02, 8'h03, 8'hF7,
            8'hF7,
            8'hFF, 8'h7F,
            8'hE3, 8'hF8, 8'h12, 8'h34
        };
        foreach (directed_bytes[i]) begin
            queue_byte(directed_bytes[i], 1'b0);
        end

        // random: mostly well-formed messages, plus broken ones and noise
        random_items = 0;
        next_drain = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain = (random_items >= next_drain);
            if (drain) begin
                next_drain += 170;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // channel message, maybe followed by running status repeats
                status = {4'($urandom_range(8, 14)), 4'($urandom)};
                n_data = (status[7:4] == HI_PROGRAM || status[7:4] == HI_CHAN_PRESS) ? 1 : 2;
                n_repeat = $urandom_range(0, 3);
                queue_byte(status, drain);
                random_items++;
                repeat ((n_repeat + 1) * n_data) begin
                    queue_byte({1'b0, 7'($urandom)}, 1'b0);
                    random_items++;
                end
            end else if (pick < 65) begin
                // sysex, usually closed by F7, sometimes cut off by a status byte
                queue_byte(SYSEX_START, drain);
                random_items++;
                repeat ($urandom_range(0, 10)) begin
                    queue_byte({1'b0, 7'($urandom)}, 1'b0);
                    random_items++;
                end
                if ($urandom_range(0, 5) != 0) begin
                    queue_byte(SYSEX_END, 1'b0);
                    random_items++;
                end
            end else if (pick < 72) begin
                // truncated channel message
                queue_byte({4'($urandom_range(8, 14)), 4'($urandom)}, drain);
                random_items++;
                if ($urandom_range(0, 1) != 0) begin
                    queue_byte({1'b0, 7'($urandom)}, 1'b0);
                    random_items++;
                end
            end else if (pick < 80) begin
                // other system bytes, skipping sysex start and end
                status = 8'($urandom_range(8'hF1, 8'hFF));
                if (status == SYSEX_END) begin
                    status = 8'hF8;
                end
                queue_byte(status, drain);
                random_items++;
            end else if (pick < 85) begin
                queue_byte(SYSEX_END, drain);
                random_items++;
            end else begin
                // noise: any byte; stray data bytes do not count as items
                status = 8'($urandom);
                queue_byte(status, drain);
                if (status[7]) begin
                    random_items++;
                end
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid || expected_packets.size() != 0) begin
            @(posedge aclk);
        end
        // output path is two stages deep; give stray results time to show
        repeat (8) @(posedge aclk);

        $display("covered %0d bytes and %0d packets (%0d sysex continue, %0d sysex end)",
                 bytes_accepted, packets_seen, sysex_cont_seen, sysex_end_seen);
        if (error_count == 0 && expected_packets.size() == 0) begin
            $display("tb_midi_to_usb_event_packer: PASS");
        end else begin
            $display("tb_midi_to_usb_event_packer: FAIL");
        end
        $finish;
    end

endmodule
